@@ src/esl_pkg.sv @@
package esl_pkg;

    // Line phase, one-hot
    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_VFIRST = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_SKIP   = 5'b10000
    } esl_phase_t;

    // Record kinds
    localparam logic [1:0] REC_VALUE    = 2'd0;
    localparam logic [1:0] REC_COMPLETE = 2'd1;
    localparam logic [1:0] REC_DISPATCH = 2'd2;

    // Field kinds
    localparam logic [1:0] FLD_EVENT = 2'd0;
    localparam logic [1:0] FLD_DATA  = 2'd1;
    localparam logic [1:0] FLD_ID    = 2'd2;
    localparam logic [1:0] FLD_RETRY = 2'd3;

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [30:0] RETRY_MAX = 31'h7FFF_FFFF;
    localparam logic [2:0]  NAME_POS_MAX = 3'd7;

    // One result record
    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        field;
        logic [7:0]        value_byte;
        logic              accepted;
        logic signed [31:0] retry_value;
        logic              has_event_type;
    } esl_rec_t;

    // Candidate field name lengths
    function automatic logic [2:0] cand_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            FLD_EVENT: len = 3'd5;
            FLD_DATA:  len = 3'd4;
            FLD_ID:    len = 3'd2;
            default:   len = 3'd5;
        endcase
        return len;
    endfunction

    // Candidate field name characters; positions past the end give NUL
    function automatic logic [7:0] cand_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (k)
            FLD_EVENT:
                unique case (pos)
                    3'd0: ch = 8'h65;
                    3'd1: ch = 8'h76;
                    3'd2: ch = 8'h65;
                    3'd3: ch = 8'h6E;
                    3'd4: ch = 8'h74;
                    default: ch = CH_NUL;
                endcase
            FLD_DATA:
                unique case (pos)
                    3'd0: ch = 8'h64;
                    3'd1: ch = 8'h61;
                    3'd2: ch = 8'h74;
                    3'd3: ch = 8'h61;
                    default: ch = CH_NUL;
                endcase
            FLD_ID:
                unique case (pos)
                    3'd0: ch = 8'h69;
                    3'd1: ch = 8'h64;
                    default: ch = CH_NUL;
                endcase
            default:
                unique case (pos)
                    3'd0: ch = 8'h72;
                    3'd1: ch = 8'h65;
                    3'd2: ch = 8'h74;
                    3'd3: ch = 8'h72;
                    3'd4: ch = 8'h79;
                    default: ch = CH_NUL;
                endcase
        endcase
        return ch;
    endfunction

endpackage

@@ src/event_stream_line_parser.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   in_byte
// output    out        out_valid / out_stall rec_kind, field_kind, value_byte, accepted,
//                                            retry_value, has_event_type
//
// One byte per clock while the output is not stalled; a byte waits in the input register
// and its record, if any, is loaded into the output register as the byte leaves it.
// The byte parser state updates in the same cycle the byte leaves the input register.
// Reset is asynchronous, active low; both registers empty, retry reads as unset.
// An output stall holds the record and backs the input register up to in_stall.
module event_stream_line_parser
    import esl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        rec_kind,
    output logic [1:0]        field_kind,
    output logic [7:0]        value_byte,
    output logic              accepted,
    output logic signed [31:0] retry_value,
    output logic              has_event_type
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    esl_rec_t   out_rec_reg;
    logic       advance;
    logic       fire;
    logic       res_valid;
    esl_rec_t   res;

    // Advance when the output slot is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    esl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_char   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= in_byte;
    end

    // Load the result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_rec_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign rec_kind       = out_rec_reg.kind;
    assign field_kind     = out_rec_reg.field;
    assign value_byte     = out_rec_reg.value_byte;
    assign accepted       = out_rec_reg.accepted;
    assign retry_value    = out_rec_reg.retry_value;
    assign has_event_type = out_rec_reg.has_event_type;

    // A stalled result stays pending
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

    // Input stall only with a request waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // No record is emitted for a byte not processed
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && advance) |=> !out_valid_reg)
        else $error("result without a processed byte");

endmodule

@@ src/esl_core.sv @@
module esl_core
    import esl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  logic [7:0] in_char,
    output logic     res_valid,
    output esl_rec_t res
);

    esl_phase_t  line_phase_reg, line_phase_next;
    logic [3:0]  name_match_reg, name_match_next;
    logic [2:0]  name_pos_reg, name_pos_next;
    logic        prev_was_cr_reg, prev_was_cr_next;
    logic        data_seen_reg, data_seen_next;
    logic        event_seen_reg, event_seen_next;
    logic        value_nul_seen_reg, value_nul_seen_next;
    logic        value_nonempty_reg, value_nonempty_next;
    logic        retry_bad_reg, retry_bad_next;
    logic [30:0] retry_accum_reg, retry_accum_next;
    logic [31:0] retry_current_reg, retry_current_next;

    // Resolve the full name seen so far to a one-hot candidate
    logic [3:0] resolved;
    always_comb
    begin
        resolved = 4'b0000;
        priority if (name_match_reg[0] && cand_len(FLD_EVENT) == name_pos_reg)
            resolved = 4'b0001;
        else if (name_match_reg[1] && cand_len(FLD_DATA) == name_pos_reg)
            resolved = 4'b0010;
        else if (name_match_reg[2] && cand_len(FLD_ID) == name_pos_reg)
            resolved = 4'b0100;
        else if (name_match_reg[3] && cand_len(FLD_RETRY) == name_pos_reg)
            resolved = 4'b1000;
        else
            resolved = 4'b0000;
    end

    // Narrow the candidates with the current name byte
    logic [3:0] match_step;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            match_step[k] = name_match_reg[k]
                && (name_pos_reg < cand_len(2'(k)))
                && (cand_char(2'(k), name_pos_reg) == in_char);
        end
    end

    // Accumulate one retry digit with saturation
    logic [34:0] retry_prod;
    logic [30:0] retry_sat;
    assign retry_prod = ({4'b0, retry_accum_reg} << 3) + ({4'b0, retry_accum_reg} << 1)
                      + {31'b0, 4'(in_char - CH_ZERO)};
    assign retry_sat  = (retry_prod > {4'b0, RETRY_MAX}) ? RETRY_MAX : retry_prod[30:0];

    // Next state and result for one byte
    always_comb
    begin
        logic [3:0] mask;
        logic       fvalid;
        logic [1:0] fidx;
        logic       acc;
        logic       is_eol;
        logic       first;

        line_phase_next     = line_phase_reg;
        name_match_next     = name_match_reg;
        name_pos_next       = name_pos_reg;
        prev_was_cr_next    = 1'b0;
        data_seen_next      = data_seen_reg;
        event_seen_next     = event_seen_reg;
        value_nul_seen_next = value_nul_seen_reg;
        value_nonempty_next = value_nonempty_reg;
        retry_bad_next      = retry_bad_reg;
        retry_accum_next    = retry_accum_reg;
        retry_current_next  = retry_current_reg;
        res_valid           = 1'b0;
        res                 = '0;
        acc                 = 1'b1;
        first               = 1'b0;
        is_eol              = (in_char == CH_CR) || (in_char == CH_LF);

        mask = (line_phase_reg == PH_NAME) ? resolved : name_match_reg;
        fvalid = 1'b1;
        fidx   = FLD_EVENT;
        unique case (mask)
            4'b0001: fidx = FLD_EVENT;
            4'b0010: fidx = FLD_DATA;
            4'b0100: fidx = FLD_ID;
            4'b1000: fidx = FLD_RETRY;
            default: fvalid = 1'b0;
        endcase

        priority if (in_char == CH_LF && prev_was_cr_reg)
        begin
            // Swallow the LF of a CRLF pair
            prev_was_cr_next = 1'b0;
        end
        else if (is_eol)
        begin
            prev_was_cr_next = (in_char == CH_CR);
            unique case (line_phase_reg)
                PH_START:
                begin
                    // Blank line: dispatch pending event
                    if (data_seen_reg)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = REC_DISPATCH;
                        res.retry_value    = retry_current_reg;
                        res.has_event_type = event_seen_reg;
                        data_seen_next     = 1'b0;
                        event_seen_next    = 1'b0;
                    end
                end
                PH_NAME, PH_VFIRST, PH_VALUE:
                begin
                    if (fvalid)
                    begin
                        unique case (fidx)
                            FLD_EVENT: event_seen_next = value_nonempty_reg;
                            FLD_DATA:  data_seen_next = 1'b1;
                            FLD_ID:    acc = value_nonempty_reg && !value_nul_seen_reg;
                            default:
                            begin
                                acc = value_nonempty_reg && !retry_bad_reg;
                                if (acc)
                                    retry_current_next = {1'b0, retry_accum_reg};
                            end
                        endcase
                        res_valid          = 1'b1;
                        res.kind           = REC_COMPLETE;
                        res.field          = fidx;
                        res.accepted       = acc;
                        res.retry_value    = retry_current_next;
                        res.has_event_type = event_seen_next;
                    end
                end
                default: ;
            endcase
            // Clear the line
            line_phase_next     = PH_START;
            name_match_next     = 4'b1111;
            name_pos_next       = 3'd0;
            value_nul_seen_next = 1'b0;
            value_nonempty_next = 1'b0;
            retry_bad_next      = 1'b0;
            retry_accum_next    = 31'd0;
        end
        else
        begin
            unique case (line_phase_reg)
                PH_START, PH_NAME:
                begin
                    priority if (line_phase_reg == PH_START && in_char == CH_COLON)
                        line_phase_next = PH_SKIP;
                    else if (in_char == CH_COLON)
                    begin
                        name_match_next = resolved;
                        line_phase_next = PH_VFIRST;
                    end
                    else
                    begin
                        line_phase_next = PH_NAME;
                        name_match_next = match_step;
                        if (name_pos_reg < NAME_POS_MAX)
                            name_pos_next = name_pos_reg + 3'd1;
                    end
                end
                PH_VFIRST, PH_VALUE:
                begin
                    first           = (line_phase_reg == PH_VFIRST);
                    line_phase_next = PH_VALUE;
                    if (!(first && in_char == CH_SPACE) && fvalid)
                    begin
                        unique case (fidx)
                            FLD_EVENT, FLD_DATA:
                            begin
                                priority if (in_char == CH_NUL)
                                    value_nul_seen_next = 1'b1;
                                else if (!value_nul_seen_reg)
                                begin
                                    value_nonempty_next = 1'b1;
                                    res_valid           = 1'b1;
                                    res.kind            = REC_VALUE;
                                    res.field           = fidx;
                                    res.value_byte      = in_char;
                                end
                                else
                                    value_nul_seen_next = 1'b1;
                            end
                            FLD_ID:
                            begin
                                if (in_char == CH_NUL)
                                    value_nul_seen_next = 1'b1;
                                value_nonempty_next = 1'b1;
                                res_valid           = 1'b1;
                                res.kind            = REC_VALUE;
                                res.field           = FLD_ID;
                                res.value_byte      = in_char;
                            end
                            default:
                            begin
                                value_nonempty_next = 1'b1;
                                if (in_char >= CH_ZERO && in_char <= CH_NINE)
                                    retry_accum_next = retry_sat;
                                else
                                    retry_bad_next = 1'b1;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        if (!fire)
            res_valid = 1'b0;
    end

    // Update parser state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_phase_reg     <= PH_START;
            name_match_reg     <= 4'b1111;
            name_pos_reg       <= 3'd0;
            prev_was_cr_reg    <= 1'b0;
            data_seen_reg      <= 1'b0;
            event_seen_reg     <= 1'b0;
            value_nul_seen_reg <= 1'b0;
            value_nonempty_reg <= 1'b0;
            retry_bad_reg      <= 1'b0;
            retry_accum_reg    <= 31'd0;
            retry_current_reg  <= 32'hFFFF_FFFF;
        end
        else if (fire)
        begin
            line_phase_reg     <= line_phase_next;
            name_match_reg     <= name_match_next;
            name_pos_reg       <= name_pos_next;
            prev_was_cr_reg    <= prev_was_cr_next;
            data_seen_reg      <= data_seen_next;
            event_seen_reg     <= event_seen_next;
            value_nul_seen_reg <= value_nul_seen_next;
            value_nonempty_reg <= value_nonempty_next;
            retry_bad_reg      <= retry_bad_next;
            retry_accum_reg    <= retry_accum_next;
            retry_current_reg  <= retry_current_next;
        end
    end

    // A pending CR always leaves the parser at line start
    a_cr_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        prev_was_cr_reg |-> line_phase_reg == PH_START)
        else $error("CR pending outside line start");

    // A dispatch clears pending data and event type
    a_dispatch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == REC_DISPATCH) |=> (!data_seen_reg && !event_seen_reg))
        else $error("dispatch left event state pending");

    // Retry is either unset or a nonnegative value
    a_retry_range: assert property (@(posedge clk) disable iff (!rst_n)
        retry_current_reg[31] |-> retry_current_reg == 32'hFFFF_FFFF)
        else $error("retry value out of range");

endmodule
